// ===== hw/rtl/mpus_pkg.sv =====
// Shared types, codes and reset constants of the modem power-up sequencer.
package mpus_pkg;

    localparam int unsigned MS_W = 16;

    // Configuration register indexes
    localparam logic [2:0] CFG_DISCHARGE      = 3'd0;
    localparam logic [2:0] CFG_GOOD_TIMEOUT   = 3'd1;
    localparam logic [2:0] CFG_SETTLE         = 3'd2;
    localparam logic [2:0] CFG_KEY_HOLD       = 3'd3;
    localparam logic [2:0] CFG_STATUS_TIMEOUT = 3'd4;

    // Register reset values, in ms
    localparam logic [MS_W-1:0] RST_DISCHARGE_MS      = 16'd1000;
    localparam logic [MS_W-1:0] RST_GOOD_TIMEOUT_MS   = 16'd100;
    localparam logic [MS_W-1:0] RST_SETTLE_MS         = 16'd500;
    localparam logic [MS_W-1:0] RST_KEY_HOLD_MS       = 16'd1250;
    localparam logic [MS_W-1:0] RST_STATUS_TIMEOUT_MS = 16'd5000;

    // Encoded phase as reported on the result channel
    localparam logic [2:0] PH_CODE_IDLE        = 3'd0;
    localparam logic [2:0] PH_CODE_DISCHARGE   = 3'd1;
    localparam logic [2:0] PH_CODE_WAIT_GOOD   = 3'd2;
    localparam logic [2:0] PH_CODE_SETTLE      = 3'd3;
    localparam logic [2:0] PH_CODE_KEY_HOLD    = 3'd4;
    localparam logic [2:0] PH_CODE_WAIT_STATUS = 3'd5;
    localparam logic [2:0] PH_CODE_READY       = 3'd6;

    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_DISCHARGE   = 7'b0000010,
        PH_WAIT_GOOD   = 7'b0000100,
        PH_SETTLE      = 7'b0001000,
        PH_KEY_HOLD    = 7'b0010000,
        PH_WAIT_STATUS = 7'b0100000,
        PH_READY       = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [MS_W-1:0] discharge_ms;
        logic [MS_W-1:0] good_timeout_ms;
        logic [MS_W-1:0] settle_ms;
        logic [MS_W-1:0] key_hold_ms;
        logic [MS_W-1:0] status_timeout_ms;
    } cfg_t;

    // Packed so that tick lands in bit 0
    typedef struct packed {
        logic error_event;
        logic status_level;
        logic power_good_level;
        logic tick;
    } in_item_t;

    // Packed so that supply_off lands in bit 0
    typedef struct packed {
        logic [2:0] phase_out;
        logic       ready_res;
        logic       good_pin_drive_low;
        logic       key_level;
        logic       supply_off;
    } out_item_t;

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        unique case (p)
            PH_IDLE:        c = PH_CODE_IDLE;
            PH_DISCHARGE:   c = PH_CODE_DISCHARGE;
            PH_WAIT_GOOD:   c = PH_CODE_WAIT_GOOD;
            PH_SETTLE:      c = PH_CODE_SETTLE;
            PH_KEY_HOLD:    c = PH_CODE_KEY_HOLD;
            PH_WAIT_STATUS: c = PH_CODE_WAIT_STATUS;
            PH_READY:       c = PH_CODE_READY;
            default:        c = PH_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/modem_power_up_sequencer.sv =====
// Top level of the modem power-up sequencer: stream channels around the phase core.
//
// Usage:
//   Slave channel (s_*) takes one transaction per sample step: a 1 ms tick flag, the
//   sampled power-good and status pin levels, and an error event. Each accepted
//   transaction yields exactly one result transaction on the master channel (m_*)
//   carrying the pin controls (supply off, key level, power-good drive low), the
//   ready flag and the encoded phase, all as they stand after that step.
//   Timeouts are set through the plain write port (cfg_wr_en/cfg_index/cfg_wdata),
//   index 0..4 in ms; other indexes are ignored. Write only while no transaction
//   is in flight.
// Timing:
//   Path: an accepted transaction passes through the input register, the phase step logic
//   (16-bit saturating count plus one compare) and the result register before m_tvalid rises.
//   Throughput is 1 transaction per cycle while m_tready stays high, as the phase register
//   and counter take one step per transaction.
// Reset (aresetn low, synchronous): phase idle, counter 0, supply cut, key released,
//   pin as input, timeouts to 1000/100/500/1250/5000 ms, both channels empty.
// Stall: while m_tready is low the result register holds; the input register still
//   takes one more transaction, then s_tready drops until the result is taken.
module modem_power_up_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] tick, [1] power_good_level, [2] status_level,
                                   // [3] error_event, [7:4] zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] supply_off, [1] key_level, [2] good_pin_drive_low,
                                   // [3] ready_res, [6:4] phase_out, [7] zero
);
    import mpus_pkg::*;

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_vld_reg, in_vld_next;
    out_item_t out_item_reg;
    out_item_t step_res;
    logic      out_vld_reg, out_vld_next;
    logic      s_fire;
    logic      step_en;

    // the held item steps the core when the result register is free or being drained
    assign step_en  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step_en;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next  = s_fire ? 1'b1 : (step_en ? 1'b0 : in_vld_reg);
        out_vld_next = step_en ? 1'b1 : ((out_vld_reg && m_tready) ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= in_item_t'(s_tdata[3:0]);
        end
        if (step_en) begin
            out_item_reg <= step_res;
        end
    end

    mpus_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpus_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_item_reg};

endmodule

// ===== hw/rtl/mpus_cfg.sv =====
// Timeout configuration registers of the modem power-up sequencer.
module mpus_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [mpus_pkg::MS_W-1:0]  cfg_wdata,
    output mpus_pkg::cfg_t             cfg
);
    import mpus_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DISCHARGE:      cfg_next.discharge_ms      = cfg_wdata;
                CFG_GOOD_TIMEOUT:   cfg_next.good_timeout_ms   = cfg_wdata;
                CFG_SETTLE:         cfg_next.settle_ms         = cfg_wdata;
                CFG_KEY_HOLD:       cfg_next.key_hold_ms       = cfg_wdata;
                CFG_STATUS_TIMEOUT: cfg_next.status_timeout_ms = cfg_wdata;
                default:            cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.discharge_ms      <= RST_DISCHARGE_MS;
            cfg_reg.good_timeout_ms   <= RST_GOOD_TIMEOUT_MS;
            cfg_reg.settle_ms         <= RST_SETTLE_MS;
            cfg_reg.key_hold_ms       <= RST_KEY_HOLD_MS;
            cfg_reg.status_timeout_ms <= RST_STATUS_TIMEOUT_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/mpus_core.sv =====
// Phase state machine and millisecond counter of the modem power-up sequencer.
module mpus_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  mpus_pkg::in_item_t   item,
    input  mpus_pkg::cfg_t       cfg,
    output mpus_pkg::out_item_t  res
);
    import mpus_pkg::*;

    localparam logic [MS_W-1:0] MS_MAX = '1;

    phase_t          phase_reg, phase_next;
    logic [MS_W-1:0] elapsed_reg, elapsed_next;
    logic            supply_off_reg, supply_off_next;
    logic            key_level_reg, key_level_next;
    logic            drive_low_reg, drive_low_next;
    logic [MS_W-1:0] elapsed_cnt;

    // saturating count, taken before the phase action
    assign elapsed_cnt = (item.tick && (elapsed_reg != MS_MAX)) ?
                         elapsed_reg + 1'b1 : elapsed_reg;

    always_comb begin
        phase_next      = phase_reg;
        elapsed_next    = elapsed_cnt;
        supply_off_next = supply_off_reg;
        key_level_next  = key_level_reg;
        drive_low_next  = drive_low_reg;
        if (item.error_event) begin
            phase_next = PH_IDLE;  // pins keep their levels
        end else begin
            unique case (phase_reg)
                PH_DISCHARGE: begin
                    if (elapsed_cnt > cfg.discharge_ms) begin
                        drive_low_next  = 1'b0;
                        supply_off_next = 1'b0;
                        phase_next      = PH_WAIT_GOOD;
                        elapsed_next    = '0;
                    end
                end
                PH_WAIT_GOOD: begin
                    if (item.power_good_level) begin
                        phase_next   = PH_SETTLE;
                        elapsed_next = '0;
                    end else if (elapsed_cnt > cfg.good_timeout_ms) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_SETTLE: begin
                    if (elapsed_cnt > cfg.settle_ms) begin
                        key_level_next = 1'b0;
                        phase_next     = PH_KEY_HOLD;
                        elapsed_next   = '0;
                    end
                end
                PH_KEY_HOLD: begin
                    if (elapsed_cnt > cfg.key_hold_ms) begin
                        key_level_next = 1'b1;
                        phase_next     = PH_WAIT_STATUS;
                        elapsed_next   = '0;
                    end
                end
                PH_WAIT_STATUS: begin
                    if (item.status_level) begin
                        phase_next   = PH_READY;
                        elapsed_next = '0;
                    end else if (elapsed_cnt > cfg.status_timeout_ms) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_READY: begin
                    phase_next = PH_READY;
                end
                default: begin  // idle
                    supply_off_next = 1'b1;
                    drive_low_next  = 1'b1;
                    phase_next      = PH_DISCHARGE;
                    elapsed_next    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            elapsed_reg    <= '0;
            supply_off_reg <= 1'b1;
            key_level_reg  <= 1'b1;
            drive_low_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            elapsed_reg    <= elapsed_next;
            supply_off_reg <= supply_off_next;
            key_level_reg  <= key_level_next;
            drive_low_reg  <= drive_low_next;
        end
    end

    // result shows the state after this step
    always_comb begin
        res.supply_off         = supply_off_next;
        res.key_level          = key_level_next;
        res.good_pin_drive_low = drive_low_next;
        res.ready_res          = (phase_next == PH_READY);
        res.phase_out          = phase_code(phase_next);
    end

`ifndef SYNTHESIS
    a_error_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.error_event) |=> (phase_reg == PH_IDLE))
        else $error("error event did not return to idle");

    a_ready_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !item.error_event && phase_reg == PH_READY) |=> (phase_reg == PH_READY))
        else $error("ready phase left without error");

    a_discharge_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DISCHARGE) |-> (supply_off_reg && drive_low_reg))
        else $error("discharge phase with supply on or pin released");

    a_key_hold_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_KEY_HOLD) |-> !key_level_reg)
        else $error("key hold phase with key released");
`endif

endmodule

// ===== sim/modem_power_up_sequencer_test.sv =====
// Self-checking testbench of the modem power-up sequencer, with its own step predictor.
module modem_power_up_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpus_pkg::*;

    localparam int          LATENCY           = 2;     // register stages, input to result
    localparam int unsigned STALL_LIMIT       = 4000;  // cycles with no transaction at all
    // Leaves idle, then counts up in discharge well below its reset timeout.
    localparam int          DEFAULT_RUN_ITEMS = 100;
    localparam int          SET_COUNT         = 6;
    localparam int          SET_ITEMS         = 250;
    localparam int          HOLD_ITEMS        = 24;    // ticks while parked in discharge
    localparam logic [2:0]  CFG_FIRST_SPARE   = 3'd5;
    localparam logic [2:0]  CFG_LAST_SPARE    = 3'd7;
    localparam logic [15:0] MS_MAX            = 16'hFFFF;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_COMB, RX_SPARSE} rx_mode_t;

    // One directed step: the sample, and a hand-typed result where it is obvious
    typedef struct packed {
        in_item_t  stim;   // {error_event, status_level, power_good_level, tick}
        logic      typed;
        out_item_t want;   // {phase_out, ready_res, good_pin_drive_low, key_level, supply_off}
    } row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [0] tick, [1] power_good_level, [2] status_level,
                                   // [3] error_event, [7:4] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [0] supply_off, [1] key_level, [2] good_pin_drive_low,
                                   // [3] ready_res, [6:4] phase_out, [7] zero

    // Predictor state: timeouts, phase, ms counter and the three pin registers
    logic [15:0] cfg_ms [0:4];
    logic [2:0]  seq_phase;
    logic [15:0] seq_elapsed_ms;
    logic        seq_supply_off;
    logic        seq_key_level;
    logic        seq_drive_low;

    out_item_t   pin_state_q [$];  // pin/phase results still owed by the block
    int          mismatches  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_cycle    = 0;
    rx_mode_t    rx_mode     = RX_OPEN;

    // Directed walk: config is all zeros, so one tick ends any timed wait.
    row_t directed_rows [24] = '{
        '{4'b1000, 1'b0, '0},                                  // force idle after defaults run
        '{4'b0000, 1'b1, {PH_CODE_DISCHARGE, 4'b0111}},        // idle: cut supply, pin low
        '{4'b0000, 1'b0, '0},                                  // no tick, discharge holds
        '{4'b0001, 1'b0, '0},                                  // discharge done, supply on
        '{4'b0001, 1'b0, '0},                                  // no power-good, timeout
        '{4'b0000, 1'b0, '0},
        '{4'b0001, 1'b0, '0},
        '{4'b0011, 1'b0, '0},                                  // power-good beats timeout
        '{4'b0001, 1'b0, '0},                                  // key pressed
        '{4'b1000, 1'b1, {PH_CODE_IDLE, 4'b0000}},             // error: key stays pressed
        '{4'b0000, 1'b0, '0},
        '{4'b0001, 1'b0, '0},
        '{4'b0010, 1'b0, '0},                                  // power-good without tick
        '{4'b0001, 1'b0, '0},
        '{4'b0001, 1'b0, '0},                                  // key released
        '{4'b0101, 1'b0, '0},                                  // status beats timeout
        '{4'b0011, 1'b0, '0},                                  // ready holds
        '{4'b1111, 1'b0, '0},                                  // all set: error wins
        '{4'b0000, 1'b0, '0},
        '{4'b0001, 1'b0, '0},
        '{4'b0010, 1'b0, '0},
        '{4'b0001, 1'b0, '0},
        '{4'b0001, 1'b0, '0},
        '{4'b0001, 1'b0, '0}                                   // status low: timeout to idle
    };

    modem_power_up_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void enter_phase(input logic [2:0] nxt);
        seq_phase      = nxt;
        seq_elapsed_ms = '0;
    endfunction

    // One sequencer step: saturating tick count, then at most one phase action.
    function automatic out_item_t advance_sequence(input in_item_t smp);
        out_item_t res;
        if (smp.tick && seq_elapsed_ms != MS_MAX)
            seq_elapsed_ms = seq_elapsed_ms + 16'd1;
        if (smp.error_event) begin
            seq_phase = PH_CODE_IDLE;   // pins keep their levels
        end else begin
            case (seq_phase)
                PH_CODE_DISCHARGE: begin
                    if (seq_elapsed_ms > cfg_ms[CFG_DISCHARGE]) begin
                        seq_drive_low  = 1'b0;
                        seq_supply_off = 1'b0;
                        enter_phase(PH_CODE_WAIT_GOOD);
                    end
                end
                PH_CODE_WAIT_GOOD: begin
                    if (smp.power_good_level)
                        enter_phase(PH_CODE_SETTLE);
                    else if (seq_elapsed_ms > cfg_ms[CFG_GOOD_TIMEOUT])
                        seq_phase = PH_CODE_IDLE;   // counter not cleared here
                end
                PH_CODE_SETTLE: begin
                    if (seq_elapsed_ms > cfg_ms[CFG_SETTLE]) begin
                        seq_key_level = 1'b0;
                        enter_phase(PH_CODE_KEY_HOLD);
                    end
                end
                PH_CODE_KEY_HOLD: begin
                    if (seq_elapsed_ms > cfg_ms[CFG_KEY_HOLD]) begin
                        seq_key_level = 1'b1;
                        enter_phase(PH_CODE_WAIT_STATUS);
                    end
                end
                PH_CODE_WAIT_STATUS: begin
                    if (smp.status_level)
                        enter_phase(PH_CODE_READY);
                    else if (seq_elapsed_ms > cfg_ms[CFG_STATUS_TIMEOUT])
                        seq_phase = PH_CODE_IDLE;
                end
                PH_CODE_READY: ;
                default: begin              // idle, and the unused code
                    seq_supply_off = 1'b1;
                    seq_drive_low  = 1'b1;
                    enter_phase(PH_CODE_DISCHARGE);
                end
            endcase
        end
        res.supply_off         = seq_supply_off;
        res.key_level          = seq_key_level;
        res.good_pin_drive_low = seq_drive_low;
        res.ready_res          = (seq_phase == PH_CODE_READY);
        res.phase_out          = seq_phase;
        return res;
    endfunction

    function automatic in_item_t random_sample();
        in_item_t smp;
        smp.tick             = ($urandom_range(0, 3) != 0);
        smp.power_good_level = 1'($urandom_range(0, 1));
        smp.status_level     = 1'($urandom_range(0, 1));
        smp.error_event      = ($urandom_range(0, 39) == 0);  // rare, so runs get deep
        return smp;
    endfunction

    function automatic logic [15:0] rand_ms(input int unsigned hi);
        return 16'($urandom_range(0, hi));
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    // Bursts of random length, a random gap before each new burst, and now and
    // then a long burst with no gaps at all.
    task automatic send_sample(input in_item_t smp, input logic typed, input out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = advance_sequence(smp);
        pin_state_q.push_back(typed ? want : predicted);
    endtask

    // Stop sending and wait for every owed result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pin_state_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx <= CFG_STATUS_TIMEOUT)
            cfg_ms[idx] = val;          // spare indexes are ignored
        @(posedge aclk);
    endtask

    // All five timeouts, then a write to a spare index that must change nothing.
    task automatic load_timeouts(input logic [15:0] dis, input logic [15:0] good,
                                 input logic [15:0] settle, input logic [15:0] key,
                                 input logic [15:0] status);
        write_reg(CFG_DISCHARGE, dis);
        write_reg(CFG_GOOD_TIMEOUT, good);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_KEY_HOLD, key);
        write_reg(CFG_STATUS_TIMEOUT, status);
        write_reg(3'($urandom_range(CFG_LAST_SPARE, CFG_FIRST_SPARE)), 16'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: check each accepted transaction, then pick next tready from
    // the current rx_mode, which is redrawn at random.
    always @(posedge aclk) begin
        out_item_t seen;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = out_item_t'(m_tdata[6:0]);
            if (pin_state_q.size() == 0) begin
                $error("result transaction %h with nothing expected", m_tdata);
                mismatches++;
            end else begin
                want = pin_state_q.pop_front();
                check_field("supply_off", 3'(want.supply_off), 3'(seen.supply_off));
                check_field("key_level", 3'(want.key_level), 3'(seen.key_level));
                check_field("good_pin_drive_low", 3'(want.good_pin_drive_low),
                            3'(seen.good_pin_drive_low));
                check_field("ready_res", 3'(want.ready_res), 3'(seen.ready_res));
                check_field("phase_out", want.phase_out, seen.phase_out);
            end
        end
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = rx_mode_t'($urandom_range(3, 0));
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
            RX_COMB:   m_tready <= (rx_cycle % 5 != 3);
            default:   m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    // Watchdog: any transaction or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("modem_power_up_sequencer_test: done, errors");
            $finish;
        end
    end

    initial begin
        in_item_t smp;
        cfg_ms[CFG_DISCHARGE]      = RST_DISCHARGE_MS;
        cfg_ms[CFG_GOOD_TIMEOUT]   = RST_GOOD_TIMEOUT_MS;
        cfg_ms[CFG_SETTLE]         = RST_SETTLE_MS;
        cfg_ms[CFG_KEY_HOLD]       = RST_KEY_HOLD_MS;
        cfg_ms[CFG_STATUS_TIMEOUT] = RST_STATUS_TIMEOUT_MS;
        seq_phase      = PH_CODE_IDLE;
        seq_elapsed_ms = '0;
        seq_supply_off = 1'b1;
        seq_key_level  = 1'b1;
        seq_drive_low  = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset timeouts: one tick per sample, power-good up, status down; the
        // sequence leaves idle and then waits out part of the reset discharge.
        smp.tick             = 1'b1;
        smp.power_good_level = 1'b1;
        smp.status_level     = 1'b0;
        smp.error_event      = 1'b0;
        repeat (DEFAULT_RUN_ITEMS) send_sample(smp, 1'b0, '0);
        drain();

        load_timeouts('0, '0, '0, '0, '0);
        foreach (directed_rows[i])
            send_sample(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Random sets: mostly short timeouts so the sequence cycles often,
        // some sets where only the pins can end the waits.
        for (int p = 0; p < SET_COUNT; p++) begin
            case (p)
                0: load_timeouts('0, '0, '0, '0, '0);
                1: load_timeouts(rand_ms(3), rand_ms(3), rand_ms(3), rand_ms(3), rand_ms(3));
                2: load_timeouts(rand_ms(12), rand_ms(12), rand_ms(12), rand_ms(12),
                                 rand_ms(12));
                3: load_timeouts(rand_ms(4), MS_MAX, rand_ms(4), rand_ms(4), MS_MAX);
                4: load_timeouts(rand_ms(6), 16'($urandom), rand_ms(6), rand_ms(6),
                                 16'($urandom));
                default: load_timeouts(rand_ms(4), rand_ms(4), rand_ms(4), rand_ms(4),
                                       rand_ms(4));
            endcase
            repeat (SET_ITEMS) send_sample(random_sample(), 1'b0, '0);
            drain();
        end

        // Longest timeout: park in discharge with ticks on every sample, which
        // must not end the wait; then lower the timeout by one and send one
        // sample without a tick.
        load_timeouts(MS_MAX, rand_ms(4), rand_ms(4), rand_ms(4), rand_ms(4));
        smp             = random_sample();
        smp.error_event = 1'b1;
        send_sample(smp, 1'b0, '0);
        repeat (HOLD_ITEMS) begin
            smp             = random_sample();
            smp.tick        = 1'b1;
            smp.error_event = 1'b0;
            send_sample(smp, 1'b0, '0);
        end
        drain();
        load_timeouts(MS_MAX - 16'd1, rand_ms(4), rand_ms(4), rand_ms(4), rand_ms(4));
        smp             = random_sample();
        smp.tick        = 1'b0;
        smp.error_event = 1'b0;
        send_sample(smp, 1'b0, '0);
        drain();

        repeat (LATENCY + 4) @(posedge aclk);
        if (mismatches == 0)
            $display("modem_power_up_sequencer_test: done, clean");
        else
            $display("modem_power_up_sequencer_test: done, errors");
        $finish;
    end

endmodule
